### src/mdss_pkg.sv
// Package for the multiplexed display scan shifter: item types, shift chain
// constants and the word packing function. No dependencies.
`timescale 1ns / 1ps

package mdss_pkg;

    localparam int SHIFT_LENGTH    = 32;
    localparam int CHAIN_LENGTH    = SHIFT_LENGTH + 1;       // data bits plus latch
    localparam int CNT_W           = $clog2(CHAIN_LENGTH + 1);
    localparam int DIGIT_W         = 4;
    localparam int PATTERN_W       = 18;
    localparam int LED_W           = 4;
    localparam int SELECT_W        = 10;
    localparam int NUM_DIGITS_DEF  = 9;

    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 18'h300FF;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [DIGIT_W-1:0]   digit_index;
        logic [PATTERN_W-1:0] segment_pattern;
    } t_in_item;

    typedef struct packed {
        logic               serial_bit;
        logic               latch_pulse;
        logic [DIGIT_W-1:0] digit_shown;
        logic               last;
    } t_out_item;

    // Contents of one shift chain cell
    typedef struct packed {
        logic serial_bit;
        logic latch_pulse;
    } t_cell_bits;

    function automatic logic [SHIFT_LENGTH-1:0] pack_word(
        input logic [PATTERN_W-1:0] pat,
        input logic [SELECT_W-1:0]  sel,
        input logic [LED_W-1:0]     led
    );
        logic [SHIFT_LENGTH-1:0] w;
        w        = '0;
        w[31:24] = pat[7:0];
        w[23:16] = pat[15:8];
        w[15:14] = sel[1:0];
        w[13:10] = led;
        w[9:8]   = pat[17:16];
        w[7:0]   = sel[9:2];
        return w;
    endfunction

endpackage

### src/multiplexed_display_scan_shifter.sv
// Multiplexed display scan shifter, top level: pattern store, digit pointer
// and a chain of 33 shift cells. Depends on mdss_pkg and mdss_shift_cell.
// The first result of a tick is presented the cycle after acceptance.
// A new tick waits until the chain drains, one cell per taken result;
// it loads in the cycle the latch item leaves.
// Write items are taken every cycle. Synchronous active-low reset clears the
// chain count, the pointer, led_status and the store valid bits.
`timescale 1ns / 1ps

module multiplexed_display_scan_shifter #(
    parameter int NUM_DIGITS = mdss_pkg::NUM_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mdss_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mdss_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [mdss_pkg::LED_W-1:0] i_cfg_data
);
    import mdss_pkg::*;

    localparam int PTR_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(NUM_DIGITS - 1);
    localparam logic [DIGIT_W-1:0] DIGIT_LIM  = DIGIT_W'(NUM_DIGITS);
    localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(CHAIN_LENGTH);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [LED_W-1:0] r_led_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_status <= '0;
        end else if (i_cfg_we) begin
            r_led_status <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Handshake. r_count = items still in the chain (0..33).
    // A tick may load when the chain is empty or its latch item is
    // leaving this cycle. Writes never wait.
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             out_take;
    logic             chain_free;
    logic             in_take;
    logic             tick_take;
    logic             wr_take;

    assign o_out_valid = (r_count != '0);
    assign out_take    = o_out_valid && !i_out_stall;
    assign chain_free  = (r_count == '0) || ((r_count == CNT_W'(1)) && out_take);
    assign o_in_stall  = (i_in_data.func == FUNC_TICK) && !chain_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign tick_take   = in_take && (i_in_data.func == FUNC_TICK);
    assign wr_take     = in_take && (i_in_data.func == FUNC_WRITE);

    always_comb begin
        n_count = r_count;
        if (tick_take) begin
            n_count = CNT_FULL;
        end else if (out_take) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // ---------------------------------------------------------------
    // Pattern store. Valid bits make unwritten entries read as the
    // reset pattern without a clearing pass.
    // ---------------------------------------------------------------
    logic [PATTERN_W-1:0]  r_store [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] r_store_vld;
    logic [PTR_W-1:0]      wr_addr;
    logic                  wr_in_range;

    assign wr_in_range = (i_in_data.digit_index < DIGIT_LIM);
    assign wr_addr     = i_in_data.digit_index[PTR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_take && wr_in_range) begin
            r_store[wr_addr] <= i_in_data.segment_pattern;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_vld <= '0;
        end else if (wr_take && wr_in_range) begin
            r_store_vld[wr_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Digit pointer and word packing
    // ---------------------------------------------------------------
    logic [PTR_W-1:0]        r_ptr;
    logic [DIGIT_W-1:0]      r_digit;      // digit of the word in the chain
    logic [PATTERN_W-1:0]    cur_pat;
    logic [SELECT_W-1:0]     cur_sel;
    logic [SHIFT_LENGTH-1:0] cur_word;

    assign cur_pat  = r_store_vld[r_ptr] ? r_store[r_ptr] : PATTERN_RESET;
    assign cur_sel  = SELECT_W'(1) << r_ptr;
    assign cur_word = pack_word(cur_pat, cur_sel, r_led_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (tick_take) begin
            r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_take) begin
            r_digit <= DIGIT_W'(r_ptr);
        end
    end

    // ---------------------------------------------------------------
    // Shift chain: cell 0 is the output register, cell 32 holds the
    // latch item. Each taken result moves every cell one step down.
    // ---------------------------------------------------------------
    t_cell_bits cell_q    [CHAIN_LENGTH];
    t_cell_bits cell_load [CHAIN_LENGTH];
    t_cell_bits cell_next [CHAIN_LENGTH];

    for (genvar g = 0; g < CHAIN_LENGTH; g++) begin : g_chain
        if (g < SHIFT_LENGTH) begin : g_data
            assign cell_load[g] = '{serial_bit: cur_word[g], latch_pulse: 1'b0};
        end else begin : g_latch
            assign cell_load[g] = '{serial_bit: 1'b0, latch_pulse: 1'b1};
        end

        if (g < CHAIN_LENGTH - 1) begin : g_link
            assign cell_next[g] = cell_q[g+1];
        end else begin : g_tail
            assign cell_next[g] = '0;
        end

        mdss_shift_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (tick_take),
            .i_shift     (out_take),
            .i_load_bits (cell_load[g]),
            .i_next_bits (cell_next[g]),
            .o_bits      (cell_q[g])
        );
    end

    assign o_out_data = '{
        serial_bit:  cell_q[0].serial_bit,
        latch_pulse: cell_q[0].latch_pulse,
        digit_shown: r_digit,
        last:        cell_q[0].latch_pulse
    };

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_tick_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_take |=> (r_count == CNT_FULL))
        else $error("tick did not fill the chain");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !tick_take) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("chain count did not step on a taken result");

    a_latch_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(1)) |-> cell_q[0].latch_pulse)
        else $error("final item is not the latch item");

    a_latch_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && cell_q[0].latch_pulse) |-> (r_count == CNT_W'(1)))
        else $error("latch item seen before the end of the run");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("digit pointer out of range");

endmodule

### src/mdss_shift_cell.sv
// One cell of the output shift chain: holds a bit and a latch flag.
// Depends on mdss_pkg.
`timescale 1ns / 1ps

module mdss_shift_cell (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic                i_shift,
    input  mdss_pkg::t_cell_bits i_load_bits,
    input  mdss_pkg::t_cell_bits i_next_bits,
    output mdss_pkg::t_cell_bits o_bits
);
    import mdss_pkg::*;

    t_cell_bits r_bits;
    t_cell_bits n_bits;

    always_comb begin
        n_bits = r_bits;
        if (i_load) begin
            n_bits = i_load_bits;
        end else if (i_shift) begin
            n_bits = i_next_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_bits = r_bits;

endmodule

### dv/tb_multiplexed_display_scan_shifter.sv
// Testbench for multiplexed_display_scan_shifter: queue-fed driver, checking monitor
// and an in-bench scan predictor of the digit store, pointer and 33-step shift run.
// Depends on mdss_pkg and the RTL under src/.
`timescale 1ns / 1ps

module tb_multiplexed_display_scan_shifter;
    import mdss_pkg::*;

    localparam int NUM_DIGITS = NUM_DIGITS_DEF;
    localparam int LONG_HOLD  = 300;     // receiver hold-off, in cycles
    localparam int DRAIN_GAP  = 4;       // settle time before a config write
    localparam int TAIL_GAP   = 50;      // quiet time at the end of the run

    // DUT ports, every input known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic      i_cfg_we    = 1'b0;
    logic [LED_W-1:0] i_cfg_data = '0;

    // Shadow copy of the block's state
    logic [PATTERN_W-1:0] pattern_store [NUM_DIGITS];
    logic [DIGIT_W-1:0]   scan_ptr;
    logic [LED_W-1:0]     led_bits;

    t_in_item  pending_items [$];        // items still to be offered
    t_out_item expected_bits [$];        // shift and latch results still owed

    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;
    logic sender_paused   = 1'b0;
    logic holdoff_req     = 1'b0;
    logic holdoff_seen    = 1'b0;
    int   holdoff_left    = 0;
    int   mismatches      = 0;

    multiplexed_display_scan_shifter #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor. A write updates the store (out-of-range digits are dropped) and
    // owes nothing. A tick owes 32 shift bits, LSB first, plus one latch result.
    task automatic predict_scan(input t_in_item it);
        logic [SHIFT_LENGTH-1:0] word;
        logic [SELECT_W-1:0]     sel;
        logic [PATTERN_W-1:0]    pat;
        t_out_item               res;
        if (it.func == FUNC_WRITE) begin
            if (it.digit_index < NUM_DIGITS)
                pattern_store[it.digit_index] = it.segment_pattern;
        end else begin
            pat  = pattern_store[scan_ptr];
            sel  = SELECT_W'(1) << scan_ptr;
            // low pattern byte ends up in the top byte of the chain
            word = {pat[7:0], pat[15:8], sel[1:0], led_bits, pat[17:16], sel[9:2]};
            for (int b = 0; b < SHIFT_LENGTH; b++) begin
                res.serial_bit  = word[b];
                res.latch_pulse = 1'b0;
                res.digit_shown = scan_ptr;
                res.last        = 1'b0;
                expected_bits.push_back(res);
            end
            res.serial_bit  = 1'b0;
            res.latch_pulse = 1'b1;
            res.digit_shown = scan_ptr;
            res.last        = 1'b1;
            expected_bits.push_back(res);
            scan_ptr = (scan_ptr == DIGIT_W'(NUM_DIGITS - 1)) ? '0 : scan_ptr + 1'b1;
        end
    endtask

    // Driver: an offered item stays put until taken; gaps are random and
    // never look at stall.
    always @(posedge i_clk) begin
        logic taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken)
                predict_scan(i_in_data);
            if (i_in_valid && !taken) begin
                // hold the stalled item
            end else if (!sender_paused && pending_items.size() != 0 &&
                         $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_items.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only reads it
    always @(posedge i_clk) begin
        if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (holdoff_req && !holdoff_seen) begin
            holdoff_left <= LONG_HOLD;
            holdoff_seen <= 1'b1;
        end
    end

    // Monitor: every taken result is checked against the oldest one owed
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_bits.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             o_out_data);
                end else begin
                    want = expected_bits.pop_front();
                    if (o_out_data.serial_bit !== want.serial_bit) begin
                        mismatches++;
                        $display("%0t: serial_bit expected %b actual %b", $time,
                                 want.serial_bit, o_out_data.serial_bit);
                    end
                    if (o_out_data.latch_pulse !== want.latch_pulse) begin
                        mismatches++;
                        $display("%0t: latch_pulse expected %b actual %b", $time,
                                 want.latch_pulse, o_out_data.latch_pulse);
                    end
                    if (o_out_data.digit_shown !== want.digit_shown) begin
                        mismatches++;
                        $display("%0t: digit_shown expected %0d actual %0d", $time,
                                 want.digit_shown, o_out_data.digit_shown);
                    end
                    if (o_out_data.last !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, o_out_data.last);
                    end
                end
            end
            i_out_stall <= (holdoff_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic queue_item(input logic func, input int idx, input int pat);
        t_in_item it;
        it.func            = func;
        it.digit_index     = DIGIT_W'(idx);
        it.segment_pattern = PATTERN_W'(pat);
        pending_items.push_back(it);
    endtask

    // Random item; tick fields are junk the block must ignore. Writes mostly
    // hit a real digit, sometimes an out-of-range one, patterns lean on extremes.
    function automatic t_in_item random_item(input int tick_pct);
        t_in_item it;
        int       roll;
        it.digit_index     = DIGIT_W'($urandom_range(15));
        it.segment_pattern = PATTERN_W'($urandom);
        it.func            = ($urandom_range(99) < tick_pct) ? FUNC_TICK : FUNC_WRITE;
        if (it.func == FUNC_WRITE) begin
            if ($urandom_range(7) != 0)
                it.digit_index = DIGIT_W'($urandom_range(NUM_DIGITS - 1));
            roll = $urandom_range(9);
            if (roll == 0)
                it.segment_pattern = '0;
            else if (roll == 1)
                it.segment_pattern = '1;
        end
        return it;
    endfunction

    // Wait until nothing is offered or owed, then let writes settle
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_bits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_led(input logic [LED_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        led_bits    = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int idle, input int stall);
        sender_idle_pct <= idle;
        recv_stall_pct  <= stall;
        repeat (n_items) pending_items.push_back(random_item(60));
        wait_drained();
    endtask

    initial begin
        for (int d = 0; d < NUM_DIGITS; d++)
            pattern_store[d] = PATTERN_RESET;
        scan_ptr = '0;
        led_bits = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset patterns on the first ticks, store extremes,
        // dropped out-of-range writes, pointer wrap, junk in tick fields.
        write_led(4'hF);
        queue_item(FUNC_TICK, 0, 0);
        queue_item(FUNC_TICK, 15, 18'h3FFFF);
        queue_item(FUNC_WRITE, 0, 18'h00000);
        queue_item(FUNC_WRITE, 1, 18'h3FFFF);
        queue_item(FUNC_WRITE, 2, 18'h2AAAA);
        queue_item(FUNC_WRITE, 3, 18'h15555);
        queue_item(FUNC_WRITE, 8, 18'h3FFFF);
        queue_item(FUNC_WRITE, NUM_DIGITS, 18'h00000);
        queue_item(FUNC_WRITE, 15, 18'h3FFFF);
        for (int k = 0; k < 11; k++)
            queue_item(FUNC_TICK, k, 18'h1F0F0);
        wait_drained();

        write_led(4'h0);
        queue_item(FUNC_WRITE, 4, 18'h0F0F0);
        queue_item(FUNC_TICK, 0, 0);
        queue_item(FUNC_TICK, 0, 0);
        queue_item(FUNC_TICK, 0, 0);
        wait_drained();

        // Random phases: free running, sender gaps, receiver stalls, both
        run_phase(22, 0, 0);
        write_led(4'h5);
        run_phase(22, 53, 0);
        write_led(4'hA);
        run_phase(22, 0, 53);
        write_led(4'($urandom_range(15)));
        run_phase(22, 8, 8);

        // Pressure: long receiver hold-off while ticks keep coming, so the
        // chain fills and the input stalls; then a sender pause mid-stream
        // until every owed result is out.
        write_led(4'hF);
        sender_idle_pct <= 0;
        recv_stall_pct  <= 20;
        repeat (20) pending_items.push_back(random_item(85));
        holdoff_req <= 1'b1;
        @(posedge i_clk);
        while (!holdoff_seen || holdoff_left != 0)
            @(posedge i_clk);
        while (pending_items.size() > 10)
            @(posedge i_clk);
        sender_paused <= 1'b1;
        @(posedge i_clk);
        while (i_in_valid || expected_bits.size() != 0)
            @(posedge i_clk);
        sender_paused <= 1'b0;
        wait_drained();

        repeat (TAIL_GAP) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
